### rtl/assert_macros.svh
// Assertion macros shared by the sequencer RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define OSD_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// Property whose consequent must hold in the cycle after the antecedent.
`define OSD_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

// Property whose consequent must hold in the same cycle as the antecedent.
`define OSD_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

`endif

### rtl/osdcws_pkg.sv
// Types, constants and the character mapping function of the OSD write sequencer.
package osdcws_pkg;

  // Character buffer geometry.
  localparam int BUF_DEPTH = 32;
  localparam int CNT_W     = $clog2(BUF_DEPTH + 1);
  localparam int IDX_W     = $clog2(BUF_DEPTH);

  // Event codes carried in the op field.
  localparam logic [2:0] OP_TICK   = 3'd0;
  localparam logic [2:0] OP_LOAD   = 3'd1;
  localparam logic [2:0] OP_STRING = 3'd2;
  localparam logic [2:0] OP_DONE   = 3'd3;
  localparam logic [2:0] OP_STATUS = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] CFG_IMAGE_ENABLE = 2'd0;
  localparam logic [1:0] CFG_PAL_MODE     = 2'd1;
  localparam logic [1:0] CFG_PASSTHROUGH  = 2'd2;

  // Chip register addresses and bit values.
  localparam logic [7:0] REG_VM0      = 8'h00;
  localparam logic [7:0] REG_DMM      = 8'h04;
  localparam logic [7:0] REG_DMAH     = 8'h05;
  localparam logic [7:0] REG_DMAL     = 8'h06;
  localparam logic [7:0] REG_OSDBL_W  = 8'h6C;
  localparam logic [7:0] REG_OSDBL_R  = 8'hEC;
  localparam logic [7:0] REG_STAT     = 8'hA0;
  localparam logic [7:0] VM0_RESET    = 8'h02;
  localparam logic [7:0] VM0_ENABLE   = 8'h08;
  localparam logic [7:0] VM0_PAL      = 8'h40;
  localparam logic [7:0] DMM_AUTO_INC = 8'h01;
  localparam logic [7:0] DMM_BLINK    = 8'h10;
  localparam logic [7:0] DMM_INVERT   = 8'h08;
  localparam logic [7:0] BL_MASK      = 8'hEF;
  localparam logic [7:0] CODE_END     = 8'hFF;

  // Screen geometry limits.
  localparam logic [4:0] ROW_MAX = 5'd15;
  localparam logic [5:0] COL_MAX = 6'd29;

  // Sequencer phases.
  typedef enum logic [3:0] {
    PH_UNINIT      = 4'd0,
    PH_INIT1       = 4'd1,
    PH_INIT2       = 4'd2,
    PH_INIT3       = 4'd3,
    PH_INIT4       = 4'd4,
    PH_READ_STATUS = 4'd5,
    PH_IDLE        = 4'd6,
    PH_S_STEP1     = 4'd7,
    PH_S_STEP2     = 4'd8,
    PH_S_STEP3     = 4'd9,
    PH_FINISHED    = 4'd10
  } phase_e;

  // One input event.
  typedef struct packed {
    logic [2:0] op;
    logic [7:0] ascii_char;
    logic [4:0] row;
    logic [5:0] column;
    logic       blink;
    logic       invert;
    logic [7:0] rx_byte;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic       frame_valid;
    logic [1:0] frame_length;
    logic [7:0] cmd_byte;
    logic [7:0] data_byte;
    logic       expect_read;
    logic [7:0] status_byte;
    logic       status_valid;
    logic       busy_res;
  } out_item_t;

  // Configuration register contents.
  typedef struct packed {
    logic image_enable;
    logic pal_mode;
    logic passthrough_chars;
  } cfg_t;

  // Buffer commands from the sequencer.
  typedef struct packed {
    logic       load;
    logic       clear;
    logic [7:0] ascii_char;
  } buf_cmd_t;

  // Buffer state seen by the sequencer.
  typedef struct packed {
    logic [CNT_W-1:0] load_count;
    logic [7:0]       rd_code;
  } buf_stat_t;

  // ASCII to font code mapping; NUL becomes the string terminator.
  function automatic logic [7:0] map_char(input logic [7:0] c);
    logic [7:0] code;
    code = c;
    case (c) inside
      8'h30:          code = c - 8'd38;
      [8'h31:8'h39]:  code = c - 8'd48;
      [8'h41:8'h5A]:  code = c - 8'd54;
      [8'h61:8'h7A]:  code = c - 8'd60;
      8'h28:          code = 8'h3F;
      8'h29:          code = 8'h40;
      8'h2E:          code = 8'h41;
      8'h3F:          code = 8'h42;
      8'h3B:          code = 8'h43;
      8'h3A:          code = 8'h44;
      8'h2C:          code = 8'h45;
      8'h2F:          code = 8'h47;
      8'h22:          code = 8'h48;
      8'h2D:          code = 8'h49;
      8'h3C:          code = 8'h4A;
      8'h3E:          code = 8'h4B;
      8'h40:          code = 8'h4C;
      8'h20:          code = 8'h00;
      8'h00:          code = CODE_END;
      default:        code = c;
    endcase
    return code;
  endfunction

endpackage

### rtl/osdcws_char_buf.sv
// Character buffer: stores mapped font codes and counts the loaded entries.
`include "assert_macros.svh"

module osdcws_char_buf (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic                          passthrough_i,
  input  osdcws_pkg::buf_cmd_t          cmd_i,
  input  logic [osdcws_pkg::IDX_W-1:0]  rd_idx_i,
  output osdcws_pkg::buf_stat_t         stat_o
);

  logic [7:0]                   mem_q [osdcws_pkg::BUF_DEPTH];
  logic [osdcws_pkg::CNT_W-1:0] count_q;
  logic [osdcws_pkg::CNT_W-1:0] count_d;
  logic                         wr_en;
  logic [7:0]                   wr_code;

  // A load is dropped once the buffer is full.
  assign wr_en   = adv_i && cmd_i.load &&
                   (count_q < osdcws_pkg::CNT_W'(osdcws_pkg::BUF_DEPTH));
  assign wr_code = passthrough_i ? cmd_i.ascii_char : osdcws_pkg::map_char(cmd_i.ascii_char);

  // Fill count: grows on each stored load, empties on the terminator frame.
  always_comb begin
    count_d = count_q;
    if (adv_i && cmd_i.clear) begin
      count_d = '0;
    end else if (wr_en) begin
      count_d = count_q + osdcws_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Storage holds no reset; only written entries are ever read.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[count_q[osdcws_pkg::IDX_W-1:0]] <= wr_code;
    end
  end

  assign stat_o.load_count = count_q;
  assign stat_o.rd_code    = mem_q[rd_idx_i];

  `OSD_ASSERT_ALWAYS(a_count_bound, count_q <= osdcws_pkg::CNT_W'(osdcws_pkg::BUF_DEPTH), "fill count beyond buffer depth")
  `OSD_ASSERT_NEXT(a_clear_empties, adv_i && cmd_i.clear, count_q == '0, "terminator did not empty the buffer")

endmodule

### rtl/osdcws_seq.sv
// Phase state machine: turns one event into at most one SPI frame and the status outputs.
`include "assert_macros.svh"

module osdcws_seq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  osdcws_pkg::in_item_t          item_i,
  input  osdcws_pkg::cfg_t              cfg_i,
  input  osdcws_pkg::buf_stat_t         buf_i,
  output osdcws_pkg::buf_cmd_t          buf_cmd_o,
  output logic [osdcws_pkg::IDX_W-1:0]  rd_idx_o,
  output osdcws_pkg::out_item_t         res_o
);

  osdcws_pkg::phase_e           phase_q, phase_d;
  logic                         applied_q, applied_d;
  logic [osdcws_pkg::CNT_W-1:0] send_q, send_d;
  logic [8:0]                   addr_q, addr_d;
  logic [1:0]                   attr_q, attr_d;
  logic [7:0]                   sreg_q, sreg_d;
  logic                         fresh_q, fresh_d;
  logic [3:0]                   row_c;
  logic [4:0]                   col_c;
  logic [8:0]                   addr_new;

  // Screen address: clamped row times 30 plus clamped column.
  assign row_c    = (item_i.row > osdcws_pkg::ROW_MAX) ? 4'd15 : item_i.row[3:0];
  assign col_c    = (item_i.column > osdcws_pkg::COL_MAX) ? 5'd29 : item_i.column[4:0];
  assign addr_new = {row_c, 5'b00000} - {4'b0000, row_c, 1'b0} + {4'b0000, col_c};

  assign rd_idx_o = send_q[osdcws_pkg::IDX_W-1:0];

  // Next state and result for the event in the input register.
  always_comb begin
    osdcws_pkg::phase_e ph;
    ph        = phase_q;
    phase_d   = phase_q;
    applied_d = applied_q;
    send_d    = send_q;
    addr_d    = addr_q;
    attr_d    = attr_q;
    sreg_d    = sreg_q;
    fresh_d   = fresh_q;
    res_o     = '0;
    buf_cmd_o.load       = 1'b0;
    buf_cmd_o.clear      = 1'b0;
    buf_cmd_o.ascii_char = item_i.ascii_char;

    case (item_i.op)
      osdcws_pkg::OP_TICK: begin
        // An enable change while idle restarts initialization.
        if (phase_q == osdcws_pkg::PH_IDLE && cfg_i.image_enable != applied_q) begin
          applied_d = cfg_i.image_enable;
          ph        = osdcws_pkg::PH_UNINIT;
          phase_d   = osdcws_pkg::PH_UNINIT;
        end
        if (ph == osdcws_pkg::PH_UNINIT) begin
          res_o.frame_valid  = 1'b1;
          res_o.frame_length = 2'd2;
          res_o.cmd_byte     = osdcws_pkg::REG_VM0;
          res_o.data_byte    = osdcws_pkg::VM0_RESET;
          phase_d            = osdcws_pkg::PH_INIT1;
        end else if (ph == osdcws_pkg::PH_INIT2) begin
          res_o.frame_valid  = 1'b1;
          res_o.frame_length = 2'd1;
          res_o.cmd_byte     = osdcws_pkg::REG_OSDBL_R;
          res_o.expect_read  = 1'b1;
          phase_d            = osdcws_pkg::PH_INIT3;
        end
      end
      osdcws_pkg::OP_LOAD: begin
        buf_cmd_o.load = 1'b1;
      end
      osdcws_pkg::OP_STRING: begin
        if (phase_q == osdcws_pkg::PH_IDLE) begin
          addr_d             = addr_new;
          attr_d             = {item_i.blink, item_i.invert};
          res_o.frame_valid  = 1'b1;
          res_o.frame_length = 2'd2;
          res_o.cmd_byte     = osdcws_pkg::REG_DMAH;
          res_o.data_byte    = {7'b0000000, addr_new[8]};
          phase_d            = osdcws_pkg::PH_S_STEP1;
        end
      end
      osdcws_pkg::OP_DONE: begin
        case (phase_q)
          osdcws_pkg::PH_INIT1: begin
            phase_d = osdcws_pkg::PH_INIT2;
          end
          osdcws_pkg::PH_INIT3: begin
            res_o.frame_valid  = 1'b1;
            res_o.frame_length = 2'd2;
            res_o.cmd_byte     = osdcws_pkg::REG_OSDBL_W;
            res_o.data_byte    = item_i.rx_byte & osdcws_pkg::BL_MASK;
            phase_d            = osdcws_pkg::PH_INIT4;
          end
          osdcws_pkg::PH_INIT4: begin
            res_o.frame_valid  = 1'b1;
            res_o.frame_length = 2'd2;
            res_o.cmd_byte     = osdcws_pkg::REG_VM0;
            res_o.data_byte    = (cfg_i.pal_mode ? osdcws_pkg::VM0_PAL : 8'h00) |
                                 (applied_q ? osdcws_pkg::VM0_ENABLE : 8'h00);
            phase_d            = osdcws_pkg::PH_FINISHED;
          end
          osdcws_pkg::PH_S_STEP1: begin
            res_o.frame_valid  = 1'b1;
            res_o.frame_length = 2'd2;
            res_o.cmd_byte     = osdcws_pkg::REG_DMAL;
            res_o.data_byte    = addr_q[7:0];
            phase_d            = osdcws_pkg::PH_S_STEP2;
          end
          osdcws_pkg::PH_S_STEP2: begin
            res_o.frame_valid  = 1'b1;
            res_o.frame_length = 2'd2;
            res_o.cmd_byte     = osdcws_pkg::REG_DMM;
            res_o.data_byte    = osdcws_pkg::DMM_AUTO_INC |
                                 (attr_q[1] ? osdcws_pkg::DMM_BLINK : 8'h00) |
                                 (attr_q[0] ? osdcws_pkg::DMM_INVERT : 8'h00);
            send_d             = '0;
            phase_d            = osdcws_pkg::PH_S_STEP3;
          end
          osdcws_pkg::PH_S_STEP3: begin
            res_o.frame_valid  = 1'b1;
            res_o.frame_length = 2'd1;
            // Send the next code, or the terminator at a stored 0xFF or the buffer end.
            if (send_q < buf_i.load_count &&
                send_q < osdcws_pkg::CNT_W'(osdcws_pkg::BUF_DEPTH) &&
                buf_i.rd_code != osdcws_pkg::CODE_END) begin
              res_o.cmd_byte = buf_i.rd_code;
              send_d         = send_q + osdcws_pkg::CNT_W'(1);
            end else begin
              res_o.cmd_byte  = osdcws_pkg::CODE_END;
              buf_cmd_o.clear = 1'b1;
              phase_d         = osdcws_pkg::PH_FINISHED;
            end
          end
          osdcws_pkg::PH_READ_STATUS: begin
            sreg_d  = item_i.rx_byte;
            fresh_d = 1'b1;
            phase_d = osdcws_pkg::PH_IDLE;
          end
          osdcws_pkg::PH_FINISHED: begin
            attr_d  = 2'b00;
            phase_d = osdcws_pkg::PH_IDLE;
          end
          default: begin
            phase_d = phase_q;
          end
        endcase
      end
      osdcws_pkg::OP_STATUS: begin
        fresh_d = 1'b0;
        if (phase_q == osdcws_pkg::PH_IDLE) begin
          res_o.frame_valid  = 1'b1;
          res_o.frame_length = 2'd1;
          res_o.cmd_byte     = osdcws_pkg::REG_STAT;
          res_o.expect_read  = 1'b1;
          phase_d            = osdcws_pkg::PH_READ_STATUS;
        end
      end
      default: begin
        phase_d = phase_q;
      end
    endcase

    res_o.status_byte  = sreg_d;
    res_o.status_valid = fresh_d;
    res_o.busy_res     = (phase_d != osdcws_pkg::PH_IDLE);
  end

  // State registers advance once per processed event.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= osdcws_pkg::PH_UNINIT;
      applied_q <= 1'b1;
      send_q    <= '0;
      addr_q    <= '0;
      attr_q    <= '0;
      sreg_q    <= '0;
      fresh_q   <= 1'b0;
    end else if (adv_i) begin
      phase_q   <= phase_d;
      applied_q <= applied_d;
      send_q    <= send_d;
      addr_q    <= addr_d;
      attr_q    <= attr_d;
      sreg_q    <= sreg_d;
      fresh_q   <= fresh_d;
    end
  end

  `OSD_ASSERT_NEXT(a_status_req, adv_i && item_i.op == osdcws_pkg::OP_STATUS && phase_q == osdcws_pkg::PH_IDLE, phase_q == osdcws_pkg::PH_READ_STATUS, "idle status request did not start a read")
  `OSD_ASSERT_NEXT(a_status_fresh, adv_i && item_i.op == osdcws_pkg::OP_DONE && phase_q == osdcws_pkg::PH_READ_STATUS, fresh_q && phase_q == osdcws_pkg::PH_IDLE, "status read completion not captured")
  `OSD_ASSERT_IMPL(a_read_frames, res_o.expect_read, phase_d == osdcws_pkg::PH_INIT3 || phase_d == osdcws_pkg::PH_READ_STATUS, "read frame outside a read phase")

endmodule

### rtl/osd_char_write_sequencer_unit.sv
// Top level of the OSD character write sequencer: channel registers, configuration and wiring.
//
// The unit takes one event per transfer on the input channel and returns exactly one result
// per event on the output channel. It sustains one event per clock cycle while the output
// channel does not stall. A result is formed from its event in the input register and is held
// in the result register until it is taken. While a result waits, the input register takes one
// more event and then holds the input off until the result is drained. Configuration writes
// take effect at the next clock edge; the user must make them only while the unit is idle, as
// it does not enforce this. The character buffer holds 32 codes; further loads are dropped.
`include "assert_macros.svh"

module osd_char_write_sequencer_unit (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  osdcws_pkg::in_item_t   in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output osdcws_pkg::out_item_t  out_data_o,
  input  logic                   cfg_we_i,
  input  logic [1:0]             cfg_idx_i,
  input  logic [0:0]             cfg_data_i
);

  logic                          in_valid_q;
  osdcws_pkg::in_item_t          in_q;
  logic                          out_valid_q;
  osdcws_pkg::out_item_t         out_q;
  osdcws_pkg::out_item_t         res;
  osdcws_pkg::cfg_t              cfg_q;
  osdcws_pkg::buf_cmd_t          buf_cmd;
  osdcws_pkg::buf_stat_t         buf_stat;
  logic [osdcws_pkg::IDX_W-1:0]  rd_idx;
  logic                          adv;

  // The held event is processed when the result register is free or being drained.
  assign adv        = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || adv;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (adv) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_enable      <= 1'b1;
      cfg_q.pal_mode          <= 1'b0;
      cfg_q.passthrough_chars <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        osdcws_pkg::CFG_IMAGE_ENABLE: cfg_q.image_enable      <= cfg_data_i[0];
        osdcws_pkg::CFG_PAL_MODE:     cfg_q.pal_mode          <= cfg_data_i[0];
        osdcws_pkg::CFG_PASSTHROUGH:  cfg_q.passthrough_chars <= cfg_data_i[0];
        default:                      cfg_q                   <= cfg_q;
      endcase
    end
  end

  osdcws_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .item_i    (in_q),
    .cfg_i     (cfg_q),
    .buf_i     (buf_stat),
    .buf_cmd_o (buf_cmd),
    .rd_idx_o  (rd_idx),
    .res_o     (res)
  );

  osdcws_char_buf u_char_buf (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .adv_i         (adv),
    .passthrough_i (cfg_q.passthrough_chars),
    .cmd_i         (buf_cmd),
    .rd_idx_i      (rd_idx),
    .stat_o        (buf_stat)
  );

  `OSD_ASSERT_NEXT(a_result_follows, adv, out_valid_q, "processed event left no result")
  `OSD_ASSERT_IMPL(a_no_overwrite, adv && out_valid_q, out_ready_i, "pending result overwritten")

endmodule
